// File: rtl/binary_signal_log_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary signal log decoder
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_SIGNAL_LOG_DECODER_ASSERT_SVH
`define BINARY_SIGNAL_LOG_DECODER_ASSERT_SVH

// same-cycle implication
`define BSLD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsld assertion failed");

// next-cycle implication
`define BSLD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsld assertion failed");

`endif

// File: rtl/bsld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsld_pkg
// Types and constants shared by the log decoder and its symbol chain.
// ----------------------------------------------------------------------------
package bsld_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int ID_WIDTH    = 32;
   localparam int VALUE_WIDTH = 64;

   localparam logic [3:0] OP_DECLARE  = 4'd0;
   localparam logic [3:0] OP_SELECT   = 4'd1;
   localparam logic [3:0] OP_SET_TIME = 4'd2;
   localparam logic [3:0] OP_ADD_TIME = 4'd3;
   localparam logic [3:0] OP_LONG     = 4'd4;
   localparam logic [3:0] OP_STRING   = 4'd5;

   localparam logic [1:0] KIND_SHORT = 2'd0;
   localparam logic [1:0] KIND_LONG  = 2'd1;
   localparam logic [1:0] KIND_CHAR  = 2'd2;

   typedef struct packed {
      logic                active;
      logic                found;
      logic [ID_WIDTH-1:0] key;
   } wave_type;

   typedef struct packed {
      logic                clear;
      logic                push;
      logic                search;
      logic [ID_WIDTH-1:0] key;
   } tbl_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } tbl_rsp_type;

endpackage

// File: rtl/bsld_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsld_cell
// One symbol slot: holds an id, shifts it on insert, and passes the search
// wave to its neighbor with its own match folded in.
// ----------------------------------------------------------------------------
module bsld_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          occupied,
   input  logic                          shift_en,
   input  logic [bsld_pkg::ID_WIDTH-1:0] shift_data,
   output logic [bsld_pkg::ID_WIDTH-1:0] id_out,
   input  bsld_pkg::wave_type            wave_in,
   output bsld_pkg::wave_type            wave_out
);
   import bsld_pkg::*;

   logic [ID_WIDTH-1:0] id_ff;
   logic [ID_WIDTH-1:0] id_in;
   wave_type            wave_ff;
   wave_type            wave_in_next;

   always_comb begin
      id_in              = shift_en ? shift_data : id_ff;
      wave_in_next       = wave_in;
      wave_in_next.found = wave_in.found | (occupied && (wave_in.key == id_ff));
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      wave_ff.found <= wave_in_next.found;
      wave_ff.key   <= wave_in_next.key;
      if (reset) begin
         wave_ff.active <= 1'b0;
      end else begin
         wave_ff.active <= wave_in_next.active;
      end
   end

   assign id_out   = id_ff;
   assign wave_out = wave_ff;

endmodule

// File: rtl/bsld_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsld_table
// Symbol table as a row of cells: inserts shift in at the head, a lookup
// walks the chain one cell per cycle.
// ----------------------------------------------------------------------------
module bsld_table #(
   parameter int SYMBOL_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsld_pkg::tbl_cmd_type cmd,
   output bsld_pkg::tbl_rsp_type rsp
);
   import bsld_pkg::*;

   localparam int CW = $clog2(SYMBOL_DEPTH + 1);

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                full;
   logic                shift_en;
   logic [ID_WIDTH-1:0] ids   [SYMBOL_DEPTH];
   wave_type            waves [SYMBOL_DEPTH];

   assign full     = (count_ff == CW'(SYMBOL_DEPTH));
   assign shift_en = cmd.push && !full && !cmd.clear;

   always_comb begin
      if (cmd.clear) begin
         count_in = '0;
      end else if (shift_en) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < SYMBOL_DEPTH; i++) begin : g_chain
      logic                occ;
      logic [ID_WIDTH-1:0] sdata;
      wave_type            win;

      assign occ = (count_ff > CW'(i));

      if (i == 0) begin : g_head
         assign sdata = cmd.key;
         assign win   = '{active: cmd.search, found: 1'b0, key: cmd.key};
      end else begin : g_body
         assign sdata = ids[i-1];
         assign win   = waves[i-1];
      end

      bsld_cell u_slot (
         .clock      (clock),
         .reset      (reset),
         .occupied   (occ),
         .shift_en   (shift_en),
         .shift_data (sdata),
         .id_out     (ids[i]),
         .wave_in    (win),
         .wave_out   (waves[i])
      );
   end

   assign rsp.done  = waves[SYMBOL_DEPTH-1].active;
   assign rsp.found = waves[SYMBOL_DEPTH-1].found;

endmodule

// File: rtl/binary_signal_log_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_signal_log_decoder
// Byte-wise decoder for a binary signal-history log, emitting value and
// string-character records with timestamp and current symbol.
// ----------------------------------------------------------------------------
//  channel | ports       | moves
//  --------+-------------+-----------------------------------------------
//  req     | valid/ready | one log byte plus start_of_file per request
//  rsp     | valid/ready | zero or one record per request, registered
//
//  One request per cycle while req_ready is high. A select ends with a walk
//  of the key down the symbol chain, with req_ready low until it is done.
//  Synchronous reset clears parser, timestamp, current symbol and fill count.
//  The result register frees req when rsp_ready takes the pending record;
//  req_ready is low while a record waits and rsp_ready is low.
// ----------------------------------------------------------------------------
module binary_signal_log_decoder #(
   parameter int SYMBOL_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_start_of_file,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_record_kind,
   output logic signed [63:0] rsp_time_stamp,
   output logic               rsp_symbol_known,
   output logic signed [31:0] rsp_symbol_id,
   output logic signed [63:0] rsp_log_value,
   output logic               rsp_last_of_record
);
   import bsld_pkg::*;

   typedef enum logic [2:0] {
      PH_OPCODE,
      PH_FIRST,
      PH_MORE,
      PH_NAME,
      PH_TEXT,
      PH_SEARCH
   } phase_type;

   phase_type              phase_ff, phase_in, phase_cur;
   logic [3:0]             left_ff, left_in, left_cur, left_dec;
   logic [3:0]             op_ff, op_in, op_cur;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in, acc_cur, acc_next;
   logic [VALUE_WIDTH-1:0] time_ff, time_in, time_cur;
   logic [ID_WIDTH-1:0]    cur_id_ff, cur_id_in, id_cur;
   logic                   cur_valid_ff, cur_valid_in, valid_cur;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_kind_ff;
   logic [VALUE_WIDTH-1:0] rsp_time_ff;
   logic                   rsp_known_ff;
   logic [ID_WIDTH-1:0]    rsp_id_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic                   rsp_last_ff;

   logic                   accept;
   logic                   sof;
   logic [BYTE_WIDTH-1:0]  b;
   logic                   emit;
   logic [1:0]             emit_kind;
   logic [VALUE_WIDTH-1:0] emit_value;
   logic                   emit_last;

   tbl_cmd_type            tbl_cmd;
   tbl_rsp_type            tbl_rsp;

   assign req_ready = (phase_ff != PH_SEARCH) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign sof       = req_start_of_file;
   assign b         = req_in_byte;

   assign phase_cur = sof ? PH_OPCODE : phase_ff;
   assign left_cur  = sof ? 4'd0 : left_ff;
   assign op_cur    = sof ? 4'd0 : op_ff;
   assign acc_cur   = sof ? '0 : acc_ff;
   assign time_cur  = sof ? '0 : time_ff;
   assign id_cur    = sof ? '0 : cur_id_ff;
   assign valid_cur = sof ? 1'b0 : cur_valid_ff;

   assign acc_next = (phase_cur == PH_FIRST) ? {{(VALUE_WIDTH-BYTE_WIDTH){b[7]}}, b}
                                             : {acc_cur[VALUE_WIDTH-BYTE_WIDTH-1:0], b};
   assign left_dec = (left_cur != 4'd0) ? left_cur - 4'd1 : left_cur;

   always_comb begin
      phase_in     = phase_ff;
      left_in      = left_ff;
      op_in        = op_ff;
      acc_in       = acc_ff;
      time_in      = time_ff;
      cur_id_in    = cur_id_ff;
      cur_valid_in = cur_valid_ff;
      emit         = 1'b0;
      emit_kind    = KIND_SHORT;
      emit_value   = '0;
      emit_last    = 1'b1;
      tbl_cmd      = '0;

      if (phase_ff == PH_SEARCH) begin
         if (tbl_rsp.done) begin
            phase_in = PH_OPCODE;
            if (tbl_rsp.found) begin
               cur_id_in    = acc_ff[ID_WIDTH-1:0];
               cur_valid_in = 1'b1;
            end
         end
      end else if (accept) begin
         phase_in      = phase_cur;
         left_in       = left_cur;
         op_in         = op_cur;
         acc_in        = acc_cur;
         time_in       = time_cur;
         cur_id_in     = id_cur;
         cur_valid_in  = valid_cur;
         tbl_cmd.clear = sof;
         case (phase_cur)
            PH_FIRST, PH_MORE: begin
               acc_in   = acc_next;
               left_in  = left_dec;
               phase_in = PH_MORE;
               if (left_dec == 4'd0) begin
                  phase_in = PH_OPCODE;
                  case (op_cur)
                     OP_DECLARE: begin
                        tbl_cmd.push = 1'b1;
                        tbl_cmd.key  = acc_next[ID_WIDTH-1:0];
                        cur_id_in    = acc_next[ID_WIDTH-1:0];
                        cur_valid_in = 1'b1;
                        phase_in     = PH_NAME;
                     end
                     OP_SELECT: begin
                        tbl_cmd.search = 1'b1;
                        tbl_cmd.key    = acc_next[ID_WIDTH-1:0];
                        phase_in       = PH_SEARCH;
                     end
                     OP_SET_TIME: time_in = acc_next;
                     OP_ADD_TIME: time_in = time_cur + acc_next;
                     OP_LONG: begin
                        emit       = 1'b1;
                        emit_kind  = KIND_LONG;
                        emit_value = acc_next;
                     end
                     OP_STRING: phase_in = PH_TEXT;
                     default: ;
                  endcase
               end
            end
            PH_NAME: begin
               if (b == '0) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_TEXT: begin
               emit       = 1'b1;
               emit_kind  = KIND_CHAR;
               emit_value = {{(VALUE_WIDTH-BYTE_WIDTH){1'b0}}, b};
               emit_last  = (b == '0);
               if (b == '0) begin
                  phase_in = PH_OPCODE;
               end
            end
            default: begin
               phase_in = PH_OPCODE;
               if (b[7]) begin
                  if (b[6]) begin
                     time_in = time_cur + {{(VALUE_WIDTH-6){1'b0}}, b[5:0]};
                  end else begin
                     emit       = 1'b1;
                     emit_kind  = KIND_SHORT;
                     emit_value = {{(VALUE_WIDTH-6){1'b0}}, b[5:0]};
                  end
               end else begin
                  op_in    = b[3:0];
                  left_in  = {1'b0, b[6:4]} + 4'd1;
                  acc_in   = '0;
                  phase_in = PH_FIRST;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         left_ff      <= '0;
         op_ff        <= '0;
         acc_ff       <= '0;
         time_ff      <= '0;
         cur_id_ff    <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         op_ff        <= op_in;
         acc_ff       <= acc_in;
         time_ff      <= time_in;
         cur_id_ff    <= cur_id_in;
         cur_valid_ff <= cur_valid_in;
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept && emit) begin
         rsp_kind_ff  <= emit_kind;
         rsp_time_ff  <= time_cur;
         rsp_known_ff <= valid_cur;
         rsp_id_ff    <= valid_cur ? id_cur : '0;
         rsp_value_ff <= emit_value;
         rsp_last_ff  <= emit_last;
      end
   end

   bsld_table #(
      .SYMBOL_DEPTH (SYMBOL_DEPTH)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .rsp   (tbl_rsp)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_kind    = rsp_kind_ff;
   assign rsp_time_stamp     = rsp_time_ff;
   assign rsp_symbol_known   = rsp_known_ff;
   assign rsp_symbol_id      = rsp_id_ff;
   assign rsp_log_value      = rsp_value_ff;
   assign rsp_last_of_record = rsp_last_ff;

endmodule

// File: rtl/bsld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsld_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_signal_log_decoder_assert.svh"

module bsld_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_in_byte,
   input logic               req_start_of_file,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_record_kind,
   input logic signed [63:0] rsp_time_stamp,
   input logic               rsp_symbol_known,
   input logic signed [31:0] rsp_symbol_id,
   input logic signed [63:0] rsp_log_value,
   input logic               rsp_last_of_record
);
   import bsld_pkg::*;

   logic is_char;
   logic is_value;

   assign is_char  = rsp_valid && (rsp_record_kind == KIND_CHAR);
   assign is_value = rsp_valid && (rsp_record_kind != KIND_CHAR);

   `BSLD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_log_value))
   `BSLD_ASSERT_NOW(a_id_zero, rsp_valid && !rsp_symbol_known, rsp_symbol_id == 32'sd0)
   `BSLD_ASSERT_NOW(a_kind_range, rsp_valid, rsp_record_kind <= KIND_CHAR)
   `BSLD_ASSERT_NOW(a_value_last, is_value, rsp_last_of_record)
   `BSLD_ASSERT_NOW(a_char_last, is_char, rsp_last_of_record == (rsp_log_value == 64'sd0))

endmodule

bind binary_signal_log_decoder bsld_checker u_bsld_checker (.*);
